[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file adfg_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define ADFG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds across reset
`define ADFG_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/adfg_pkg.sv]
// ----------------------------------------------------------------------------
// adfg_pkg
// Shared types, constants and the square lookup for the ADFGVX encoder.
// ----------------------------------------------------------------------------
package adfg_pkg;

  localparam int PART_W = 54;
  localparam int SQ_W   = 4 * PART_W;
  localparam int KEY_W  = 64;
  localparam int CFG_W  = 64;
  localparam int KLEN_W = 4;

  localparam logic [5:0] NUM_SYMBOLS = 6'd36;
  localparam logic [2:0] LTR_X       = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_SQ0     = 3'd0;
  localparam logic [2:0] REG_SQ1     = 3'd1;
  localparam logic [2:0] REG_SQ2     = 3'd2;
  localparam logic [2:0] REG_SQ3     = 3'd3;
  localparam logic [2:0] REG_KEY     = 3'd4;
  localparam logic [2:0] REG_KEY_LEN = 3'd5;

  // padding symbols: x, v, g, f, d, a
  localparam logic [5:0] PAD_SYM [6] = '{6'd23, 6'd21, 6'd6, 6'd5, 6'd3, 6'd0};

  typedef struct packed {
    logic       letter;   // symbol maps to a square entry
    logic [2:0] row;
    logic [2:0] col;
    logic       last;
  } adfg_entry_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] letter;
    logic       column_end;
    logic       final_res;
  } adfg_res_t;

  // Row (which=0) or column (which=1) code of a symbol; codes 6 and 7 read as X.
  function automatic logic [2:0] square_code(logic [SQ_W-1:0] sq, logic [5:0] sym,
                                             logic which);
    logic [5:0] s;
    logic [1:0] part;
    logic [5:0] slot;
    logic [7:0] idx;
    logic [2:0] v;
    s = (sym < NUM_SYMBOLS) ? sym : 6'd0;
    if (s >= 6'd27) begin
      part = 2'd3;
      slot = s - 6'd27;
    end else if (s >= 6'd18) begin
      part = 2'd2;
      slot = s - 6'd18;
    end else if (s >= 6'd9) begin
      part = 2'd1;
      slot = s - 6'd9;
    end else begin
      part = 2'd0;
      slot = s;
    end
    idx = 8'(part) * 8'(PART_W) + 8'(slot) * 8'd6 + (which ? 8'd3 : 8'd0);
    v = sq[idx +: 3];
    return (v > LTR_X) ? LTR_X : v;
  endfunction

endpackage

[sv/adfg_ram.sv]
// ----------------------------------------------------------------------------
// adfg_ram
// Generic single write port RAM with a registered read port.
// ----------------------------------------------------------------------------
module adfg_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 56
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/adfg_front.sv]
// ----------------------------------------------------------------------------
// adfg_front
// Accepts symbols, classifies them and looks up their square codes.
// ----------------------------------------------------------------------------
module adfg_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [5:0]                  symbol,
  input  logic                        last,
  output logic                        busy,
  input  logic [adfg_pkg::SQ_W-1:0]   square,
  input  logic                        q_full,
  output logic                        push,
  output adfg_pkg::adfg_entry_t       entry
);

  logic                  stage_v_r, stage_v_nxt;
  adfg_pkg::adfg_entry_t stage_r, stage_nxt;
  logic                  accept;

  assign busy   = stage_v_r && q_full;
  assign accept = start && !busy;
  assign push   = stage_v_r;
  assign entry  = stage_r;

  always_comb begin
    stage_v_nxt = stage_v_r;
    stage_nxt   = stage_r;
    if (accept) begin
      stage_v_nxt      = 1'b1;
      stage_nxt.letter = (symbol < adfg_pkg::NUM_SYMBOLS);
      stage_nxt.row    = adfg_pkg::square_code(square, symbol, 1'b0);
      stage_nxt.col    = adfg_pkg::square_code(square, symbol, 1'b1);
      stage_nxt.last   = last;
    end else if (stage_v_r && !q_full) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
    stage_r <= stage_nxt;
  end

endmodule

[sv/adfg_queue.sv]
// ----------------------------------------------------------------------------
// adfg_queue
// Two-entry queue between the front and back halves.
// ----------------------------------------------------------------------------
module adfg_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  adfg_pkg::adfg_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  valid,
  output adfg_pkg::adfg_entry_t head
);

  adfg_pkg::adfg_entry_t slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign head    = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wp_r] <= push_entry;
    end
  end

endmodule

[sv/adfg_back.sv]
// ----------------------------------------------------------------------------
// adfg_back
// Stores letters, pads to full rows, ranks the key and reads columns out.
// ----------------------------------------------------------------------------
module adfg_back #(
  parameter int MAX_SYMBOLS = 24,
  parameter int MAX_KEY     = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [adfg_pkg::SQ_W-1:0]    square,
  input  logic [adfg_pkg::KEY_W-1:0]   key_letters,
  input  logic [$clog2(MAX_KEY+1)-1:0] key_len,
  input  logic                         q_valid,
  input  adfg_pkg::adfg_entry_t        q_entry,
  output logic                         q_pop,
  output adfg_pkg::adfg_res_t          res
);

  localparam int STORE_DEPTH = 2 * MAX_SYMBOLS + MAX_KEY;
  localparam int LOAD_LIMIT  = 2 * MAX_SYMBOLS;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int KW = $clog2(MAX_KEY + 1);
  localparam int IW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_COL  = 6'b000010,
    S_DIV  = 6'b000100,
    S_PAD  = 6'b001000,
    S_SORT = 6'b010000,
    S_READ = 6'b100000
  } back_state_t;

  back_state_t   state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] rows_r, rows_nxt;
  logic [KW-1:0] colpos_r, colpos_nxt;
  logic [2:0]    pad_i_r, pad_i_nxt;
  logic [IW-1:0] sort_i_r, sort_i_nxt;
  logic [IW-1:0] order_r [MAX_KEY];
  logic [IW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] row_off_r, row_off_nxt;
  logic [2:0]    col_hold_r, col_hold_nxt;
  logic          last_hold_r, last_hold_nxt;
  logic          out_v_r, out_v_nxt;
  logic          colend_r, colend_nxt;
  logic          final_r, final_nxt;

  logic [7:0]    kb [MAX_KEY];
  logic [7:0]    kb_i;
  logic [IW-1:0] rank;
  logic          order_we;
  logic          last_row, last_col;
  logic [CW-1:0] rd_sum;
  logic [2:0]    pad_code;
  logic          we;
  logic [2:0]    wdata;
  logic          re;
  logic [2:0]    rdata;

  always_comb begin
    for (int j = 0; j < MAX_KEY; j++) begin
      kb[j] = key_letters[8*j +: 8];
    end
  end

  assign kb_i = kb[sort_i_r];

  // stable rank: smaller keys, plus equal keys in earlier columns
  always_comb begin
    rank = '0;
    for (int j = 0; j < MAX_KEY; j++) begin
      if ((KW'(j) < key_len) &&
          ((kb[j] < kb_i) || ((kb[j] == kb_i) && (IW'(j) < sort_i_r)))) begin
        rank = rank + IW'(1);
      end
    end
  end

  assign last_row = ((row_r + CW'(1)) == rows_r);
  assign last_col = ((KW'(col_r) + KW'(1)) == key_len);
  assign rd_sum   = row_off_r + CW'(order_r[col_r]);
  assign pad_code = adfg_pkg::square_code(square,
                      adfg_pkg::PAD_SYM[{1'b0, pad_i_r[2:1]}], pad_i_r[0]);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    rows_nxt      = rows_r;
    colpos_nxt    = colpos_r;
    pad_i_nxt     = pad_i_r;
    sort_i_nxt    = sort_i_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    row_off_nxt   = row_off_r;
    col_hold_nxt  = col_hold_r;
    last_hold_nxt = last_hold_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    wdata         = q_entry.row;
    re            = 1'b0;
    order_we      = 1'b0;
    out_v_nxt     = 1'b0;
    colend_nxt    = 1'b0;
    final_nxt     = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_entry.letter && (count_r < CW'(LOAD_LIMIT))) begin
            we            = 1'b1;
            wdata         = q_entry.row;
            count_nxt     = count_r + CW'(1);
            col_hold_nxt  = q_entry.col;
            last_hold_nxt = q_entry.last;
            state_nxt     = S_COL;
          end else if (q_entry.last && (count_r != '0)) begin
            rem_nxt   = count_r;
            rows_nxt  = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_COL: begin
        we        = 1'b1;
        wdata     = col_hold_r;
        count_nxt = count_r + CW'(1);
        if (last_hold_r) begin
          rem_nxt   = count_r + CW'(1);
          rows_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_DIV: begin
        // full rows and the remainder, one subtraction a cycle
        if (rem_r >= CW'(key_len)) begin
          rem_nxt  = rem_r - CW'(key_len);
          rows_nxt = rows_r + CW'(1);
        end else begin
          colpos_nxt = KW'(rem_r);
          pad_i_nxt  = '0;
          sort_i_nxt = '0;
          state_nxt  = (rem_r == '0) ? S_SORT : S_PAD;
        end
      end
      S_PAD: begin
        we        = 1'b1;
        wdata     = pad_code;
        count_nxt = count_r + CW'(1);
        pad_i_nxt = pad_i_r + 3'd1;
        if ((colpos_r + KW'(1)) == key_len) begin
          rows_nxt  = rows_r + CW'(1);
          state_nxt = S_SORT;
        end else begin
          colpos_nxt = colpos_r + KW'(1);
        end
      end
      S_SORT: begin
        order_we = 1'b1;
        if ((KW'(sort_i_r) + KW'(1)) == key_len) begin
          col_nxt     = '0;
          row_nxt     = '0;
          row_off_nxt = '0;
          state_nxt   = S_READ;
        end else begin
          sort_i_nxt = sort_i_r + IW'(1);
        end
      end
      S_READ: begin
        re         = 1'b1;
        out_v_nxt  = 1'b1;
        colend_nxt = last_row;
        final_nxt  = last_row && last_col;
        if (last_row) begin
          row_nxt     = '0;
          row_off_nxt = '0;
          if (last_col) begin
            count_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            col_nxt = col_r + IW'(1);
          end
        end else begin
          row_nxt     = row_r + CW'(1);
          row_off_nxt = row_off_r + CW'(key_len);
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      count_r  <= '0;
      out_v_r  <= 1'b0;
      colend_r <= 1'b0;
      final_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      out_v_r  <= out_v_nxt;
      colend_r <= colend_nxt;
      final_r  <= final_nxt;
    end
    rem_r       <= rem_nxt;
    rows_r      <= rows_nxt;
    colpos_r    <= colpos_nxt;
    pad_i_r     <= pad_i_nxt;
    sort_i_r    <= sort_i_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    row_off_r   <= row_off_nxt;
    col_hold_r  <= col_hold_nxt;
    last_hold_r <= last_hold_nxt;
    if (order_we) begin
      order_r[rank] <= sort_i_r;
    end
  end

  adfg_ram #(
    .WIDTH(3),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(count_r[AW-1:0]),
    .wdata(wdata),
    .re   (re),
    .raddr(rd_sum[AW-1:0]),
    .rdata(rdata)
  );

  assign res.valid      = out_v_r;
  assign res.letter     = rdata;
  assign res.column_end = colend_r;
  assign res.final_res  = final_r;

endmodule

[sv/adfgvx_cipher_encoder.sv]
// ----------------------------------------------------------------------------
// adfgvx_cipher_encoder
// ADFGVX encoder: square substitution followed by keyed column transposition.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a symbol is taken on a clock edge with start high and busy low.
//   Symbols 0-35 become two letters; anything else is skipped. in_last ends
//   the message and starts the readout.
//   Output: one ciphertext letter per cycle while out_valid is high, with
//   out_column_end on each column's last letter and out_final_res on the
//   last letter of the message. The receiver cannot stall; results are
//   never held back once the readout has started.
//   Config: cfg_ready is always high; write only while no message is open.
// Flow:
//   The back end stores a symbol as its row letter, then its column
//   letter (one store write port); a skipped symbol is popped unstored.
//   A front register and a two-entry queue let symbols be accepted while
//   the back end works. After the last symbol come the row count by
//   repeated subtraction, up to k - 1 padding letters, the key ranking and
//   n + pad letters from a registered read at one a cycle, the first in the
//   cycle after the readout starts. Reset restores the register defaults
//   and empties the queue; only the letter count is cleared, not the store.
// ----------------------------------------------------------------------------
module adfgvx_cipher_encoder #(
  parameter int MAX_SYMBOLS = 24,
  parameter int MAX_KEY     = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [5:0]                in_symbol,
  input  logic                      in_last,
  output logic                      out_valid,
  output logic [2:0]                out_cipher_letter,
  output logic                      out_column_end,
  output logic                      out_final_res,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [adfg_pkg::CFG_W-1:0] cfg_data
);

  localparam int KW = $clog2(MAX_KEY + 1);
  localparam int PW = adfg_pkg::PART_W;

  logic [PW-1:0]                  sq0_r, sq1_r, sq2_r, sq3_r;
  logic [adfg_pkg::KEY_W-1:0]     key_r;
  logic [adfg_pkg::KLEN_W-1:0]    klen_r;
  logic [adfg_pkg::SQ_W-1:0]      square;
  logic [KW-1:0]                  k_eff;
  logic                           cfg_we;

  logic                  f_push;
  adfg_pkg::adfg_entry_t f_entry;
  logic                  q_full, q_valid, q_pop;
  adfg_pkg::adfg_entry_t q_head;
  adfg_pkg::adfg_res_t   res;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign square    = {sq3_r, sq2_r, sq1_r, sq0_r};

  // key length 0 counts as 1, anything above the column limit as the limit
  always_comb begin
    if (klen_r == '0) begin
      k_eff = KW'(1);
    end else if (klen_r > adfg_pkg::KLEN_W'(MAX_KEY)) begin
      k_eff = KW'(MAX_KEY);
    end else begin
      k_eff = KW'(klen_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq0_r  <= '0;
      sq1_r  <= '0;
      sq2_r  <= '0;
      sq3_r  <= '0;
      key_r  <= '0;
      klen_r <= adfg_pkg::KLEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        adfg_pkg::REG_SQ0:     sq0_r  <= cfg_data[PW-1:0];
        adfg_pkg::REG_SQ1:     sq1_r  <= cfg_data[PW-1:0];
        adfg_pkg::REG_SQ2:     sq2_r  <= cfg_data[PW-1:0];
        adfg_pkg::REG_SQ3:     sq3_r  <= cfg_data[PW-1:0];
        adfg_pkg::REG_KEY:     key_r  <= cfg_data;
        adfg_pkg::REG_KEY_LEN: klen_r <= cfg_data[adfg_pkg::KLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  adfg_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .symbol(in_symbol),
    .last  (in_last),
    .busy  (busy),
    .square(square),
    .q_full(q_full),
    .push  (f_push),
    .entry (f_entry)
  );

  adfg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_entry(f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  adfg_back #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .MAX_KEY    (MAX_KEY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .square     (square),
    .key_letters(key_r),
    .key_len    (k_eff),
    .q_valid    (q_valid),
    .q_entry    (q_head),
    .q_pop      (q_pop),
    .res        (res)
  );

  assign out_valid         = res.valid;
  assign out_cipher_letter = res.letter;
  assign out_column_end    = res.column_end;
  assign out_final_res     = res.final_res;

endmodule

[sv/adfg_checker.sv]
// ----------------------------------------------------------------------------
// adfg_checker
// Port-level checks on the encoder's result stream and busy, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adfg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_cipher_letter,
  input logic       out_column_end,
  input logic       out_final_res
);

  `ADFG_ASSERT(a_letter_range, clk, rst_n, out_valid |-> (out_cipher_letter <= adfg_pkg::LTR_X), "cipher letter out of range")

  `ADFG_ASSERT(a_final_ends_column, clk, rst_n, (out_valid && out_final_res) |-> out_column_end, "final letter does not end a column")

  `ADFG_ASSERT(a_flags_need_beat, clk, rst_n, !out_valid |-> (!out_column_end && !out_final_res), "flags raised without a beat")

  `ADFG_ASSERT(a_gap_after_final, clk, rst_n, (out_valid && out_final_res) |=> !out_valid, "beat right after the final letter")

  `ADFG_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> (!out_valid && !busy), "output or busy active after reset")

endmodule

bind adfgvx_cipher_encoder adfg_checker u_adfg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_cipher_letter(out_cipher_letter),
  .out_column_end   (out_column_end),
  .out_final_res    (out_final_res)
);
